// ----- rtl/core/hete_pkg.sv -----
// hete_pkg: types, codes and sizes shared by the hashed entry table with aging
// used by hete_ctrl, hete_dpath and hashed_entry_table_with_aging_core
`default_nettype none

package hete_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int TAG_W         = 32;

    localparam logic [1:0] OP_PROBE      = 2'd0;
    localparam logic [1:0] OP_STORE      = 2'd1;
    localparam logic [1:0] OP_NEW_SEARCH = 2'd2;
    localparam logic [1:0] OP_CLEAR      = 2'd3;

    localparam logic [1:0] BOUND_NONE  = 2'd0;
    localparam logic [1:0] BOUND_EXACT = 2'd1;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [15:0]      score;
        logic [15:0]      eval;
        logic [15:0]      mv;
        logic [7:0]       depth;
        logic [1:0]       bound;
        logic [7:0]       age;
    } t_entry;

    typedef struct packed {
        logic load;
        logic exec;
        logic sweep;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       sweep_last;
        logic       out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- rtl/core/hete_ctrl.sv -----
// hete_ctrl: state machine that sequences clear sweeps, request intake and execution
// depends on hete_pkg
`default_nettype none

module hete_ctrl
    import hete_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    localparam logic [1:0] S_SWEEP = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;
    logic       exec_go;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);
    assign exec_go = (r_state == S_EXEC) && i_status.out_free;

    assign o_cmd.load  = accept;
    assign o_cmd.exec  = exec_go;
    assign o_cmd.sweep = (r_state == S_SWEEP);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_SWEEP: begin
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state = (i_status.op == OP_CLEAR) ? S_SWEEP : S_IDLE;
                end
            end
            default: begin
                n_state = S_SWEEP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/hete_dpath.sv -----
// hete_dpath: slot memory, request registers, replacement logic, age and result register
// depends on hete_pkg
`default_nettype none

module hete_dpath
    import hete_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_status              o_status,
    input  wire logic [1:0]         i_op,
    input  wire logic [63:0]        i_key,
    input  wire logic [7:0]         i_search_depth,
    input  wire logic signed [15:0] i_score_value,
    input  wire logic [1:0]         i_bound_kind,
    input  wire logic [15:0]        i_move_code,
    input  wire logic signed [15:0] i_eval_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_hit,
    output logic [7:0]              o_found_depth,
    output logic signed [15:0]      o_found_score,
    output logic [1:0]              o_found_bound,
    output logic [15:0]             o_found_move,
    output logic signed [15:0]      o_found_eval,
    output logic [7:0]              o_found_age
);

    t_entry           r_mem [TABLE_ENTRIES];
    t_entry           r_rd;

    logic [1:0]       r_op;
    logic [IDX_W-1:0] r_idx;
    logic [TAG_W-1:0] r_tag;
    logic [7:0]       r_depth;
    logic [15:0]      r_score;
    logic [1:0]       r_bound;
    logic [15:0]      r_move;
    logic [15:0]      r_eval;

    logic [7:0]       r_age;
    logic [IDX_W-1:0] r_sweep_idx;
    logic             r_out_valid;
    t_entry           r_out;
    logic             r_hit;

    logic             hit;
    logic             replace;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;
    t_entry           store_entry;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_idx   <= i_key[IDX_W-1:0];
            r_tag   <= i_key[63:32];
            r_depth <= i_search_depth;
            r_score <= i_score_value;
            r_bound <= i_bound_kind;
            r_move  <= i_move_code;
            r_eval  <= i_eval_value;
            r_rd    <= r_mem[i_key[IDX_W-1:0]];
        end
    end

    assign hit = (r_op == OP_PROBE) && (r_rd.bound != BOUND_NONE) && (r_rd.tag == r_tag);

    assign replace = (r_rd.bound == BOUND_NONE)
                  || (r_rd.age != r_age)
                  || (r_depth >= r_rd.depth)
                  || ((r_bound == BOUND_EXACT) && (r_rd.bound != BOUND_EXACT));

    always_comb begin
        store_entry.tag   = r_tag;
        store_entry.score = r_score;
        store_entry.eval  = r_eval;
        store_entry.mv    = r_move;
        store_entry.depth = r_depth;
        store_entry.bound = r_bound;
        store_entry.age   = r_age;
        // null move keeps the stored move of the same position
        if ((r_rd.tag == r_tag) && (r_move == 16'd0) && (r_rd.mv != 16'd0)) begin
            store_entry.mv = r_rd.mv;
        end
    end

    assign wr_en   = i_cmd.sweep || (i_cmd.exec && (r_op == OP_STORE) && replace);
    assign wr_addr = i_cmd.sweep ? r_sweep_idx : r_idx;
    assign wr_data = i_cmd.sweep ? '0 : store_entry;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age       <= '0;
            r_sweep_idx <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.sweep) begin
                r_sweep_idx <= r_sweep_idx + 1'b1;
            end
            if (i_cmd.exec && (r_op == OP_NEW_SEARCH)) begin
                r_age <= r_age + 8'd1;
            end else if (i_cmd.exec && (r_op == OP_CLEAR)) begin
                r_age <= '0;
            end
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_hit <= hit;
            r_out <= hit ? r_rd : '0;
        end
    end

    assign o_status.op         = r_op;
    assign o_status.sweep_last = &r_sweep_idx;
    assign o_status.out_free   = !r_out_valid || !i_stall;

    assign o_valid       = r_out_valid;
    assign o_hit         = r_hit;
    assign o_found_depth = r_out.depth;
    assign o_found_score = $signed(r_out.score);
    assign o_found_bound = r_out.bound;
    assign o_found_move  = r_out.mv;
    assign o_found_eval  = $signed(r_out.eval);
    assign o_found_age   = r_out.age;

endmodule

`default_nettype wire

// ----- rtl/core/hashed_entry_table_with_aging_core.sv -----
// hashed_entry_table_with_aging_core: direct-mapped result table with aging replacement
// depends on hete_pkg, hete_ctrl and hete_dpath
//
//   channel   | handshake            | payload
//   ----------+----------------------+----------------------------------------------
//   request   | i_valid / o_stall    | i_op i_key i_search_depth i_score_value
//             |                      | i_bound_kind i_move_code i_eval_value
//   result    | o_valid / i_stall    | o_hit o_found_depth o_found_score o_found_bound
//             |                      | o_found_move o_found_eval o_found_age
//
// each request runs one registered read of the slot memory, then
// the compare, write-back and result load; one request is in flight at a time
// a new request is taken while the previous result still waits in its register
// reset and each clear request run a zeroing sweep of all 1024 slots of the slot memory,
// one slot per cycle, with o_stall high throughout
// a stalled result holds the next request in its execute cycle until the register frees
`default_nettype none

module hashed_entry_table_with_aging_core
    import hete_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_op,
    input  wire logic [63:0]        i_key,
    input  wire logic [7:0]         i_search_depth,
    input  wire logic signed [15:0] i_score_value,
    input  wire logic [1:0]         i_bound_kind,
    input  wire logic [15:0]        i_move_code,
    input  wire logic signed [15:0] i_eval_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_hit,
    output logic [7:0]              o_found_depth,
    output logic signed [15:0]      o_found_score,
    output logic [1:0]              o_found_bound,
    output logic [15:0]             o_found_move,
    output logic signed [15:0]      o_found_eval,
    output logic [7:0]              o_found_age
);

    t_dp_cmd    cmd;
    t_dp_status status;

    hete_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    hete_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_op           (i_op),
        .i_key          (i_key),
        .i_search_depth (i_search_depth),
        .i_score_value  (i_score_value),
        .i_bound_kind   (i_bound_kind),
        .i_move_code    (i_move_code),
        .i_eval_value   (i_eval_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_hit          (o_hit),
        .o_found_depth  (o_found_depth),
        .o_found_score  (o_found_score),
        .o_found_bound  (o_found_bound),
        .o_found_move   (o_found_move),
        .o_found_eval   (o_found_eval),
        .o_found_age    (o_found_age)
    );

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request taken while another is in flight");

    a_no_exec_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.sweep |-> (!cmd.exec && !cmd.load))
        else $error("request handled during memory sweep");

    a_hit_is_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (o_found_bound != BOUND_NONE))
        else $error("hit reported on an empty slot");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> ((o_found_depth == 8'd0) && (o_found_score == 16'sd0)
            && (o_found_bound == BOUND_NONE) && (o_found_move == 16'd0)
            && (o_found_eval == 16'sd0) && (o_found_age == 8'd0)))
        else $error("miss result carries slot data");

endmodule

`default_nettype wire
